/* rtl/tsts_pkg.sv */
// ----------------------------------------------------------------------------
// Target seek package
// Shared types, codes and reset values of the three-sonar target seek block.
// ----------------------------------------------------------------------------
package tsts_pkg;

  localparam int unsigned DistW  = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ToutW  = 16;
  localparam int unsigned MissW  = 4;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    ModeSearch   = 3'b001,
    ModeApproach = 3'b010,
    ModeRotating = 3'b100
  } mode_e;

  localparam logic [ModeW-1:0] ModeCodeSearch   = 2'd0;
  localparam logic [ModeW-1:0] ModeCodeApproach = 2'd1;
  localparam logic [ModeW-1:0] ModeCodeRotating = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CmdNone    = 3'd0,
    CmdForward = 3'd1,
    CmdStop    = 3'd2,
    CmdCcw     = 3'd3,
    CmdCw      = 3'd4
  } motor_cmd_e;

  localparam logic [CfgIdxW-1:0] CfgMiddleThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSideThreshold   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGripThreshold   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRotateTimeout   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMissLimit       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCruiseSpeed     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTurnSpeed       = 3'd6;

  localparam logic [DistW-1:0]  RstMiddleThreshold = 10'd50;
  localparam logic [DistW-1:0]  RstSideThreshold   = 10'd50;
  localparam logic [DistW-1:0]  RstGripThreshold   = 10'd10;
  localparam logic [ToutW-1:0]  RstRotateTimeout   = 16'd5000;
  localparam logic [MissW-1:0]  RstMissLimit       = 4'd4;
  localparam logic [SpeedW-1:0] RstCruiseSpeed     = 8'd100;
  localparam logic [SpeedW-1:0] RstTurnSpeed       = 8'd105;

endpackage

/* rtl/three_sonar_target_seek_fsm.sv */
// ----------------------------------------------------------------------------
// Three-sonar target seek controller
// Runs one control pass per input word: search, approach and timed rotation
// toward an object seen by three sonars, with motor and speed commands out.
// ----------------------------------------------------------------------------
// Usage:
// An input word carries the left, middle and right distances and the current
// millisecond time. It is accepted when in_valid_i is high and in_stall_o is
// low. Each word produces exactly one result word on the output channel,
// accepted when out_valid_o is high and out_stall_i is low.
// The word is captured in an input register, the pass is evaluated from that
// register and the result lands in the output register that drives
// out_valid_o. One word is taken every cycle while the receiver does not
// stall; the state update from input register to output register sets the
// rate. While the receiver stalls, the result holds, one more word may wait
// in the input register, and then in_stall_o is raised.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, which the block does not
// enforce. Reset sets search mode, clears the miss count, deadline and turn
// direction, restores config defaults and empties both pipeline registers.
// ----------------------------------------------------------------------------
module three_sonar_target_seek_fsm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsts_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsts_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tsts_pkg::DistW-1:0]      dist_left_i,
  input  logic [tsts_pkg::DistW-1:0]      dist_middle_i,
  input  logic [tsts_pkg::DistW-1:0]      dist_right_i,
  input  logic [tsts_pkg::TimeW-1:0]      now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tsts_pkg::CmdW-1:0]       motor_cmd_o,
  output logic                            speed_write_o,
  output logic [tsts_pkg::SpeedW-1:0]     speed_value_o,
  output logic                            grip_ready_o,
  output logic                            extra_turn_o,
  output logic [tsts_pkg::ModeW-1:0]      mode_now_o
);
  import tsts_pkg::*;

  logic [DistW-1:0]  middle_thr_q, side_thr_q, grip_thr_q;
  logic [ToutW-1:0]  rotate_tout_q;
  logic [MissW-1:0]  miss_limit_q;
  logic [SpeedW-1:0] cruise_speed_q, turn_speed_q;

  logic              in_valid_q;
  logic [DistW-1:0]  dl_q, dm_q, dr_q;
  logic [TimeW-1:0]  now_q;

  mode_e             mode_q, mode_d;
  logic              turn_dir_q, turn_dir_d;
  logic [TimeW-1:0]  deadline_q, deadline_d;
  logic [MissW-1:0]  miss_q, miss_d, miss_inc;

  logic              out_valid_q;
  motor_cmd_e        cmd_q, cmd_d;
  logic              spd_w_q, spd_w_d;
  logic [SpeedW-1:0] spd_q, spd_d;
  logic              ready_q, ready_d;
  logic              extra_q, extra_d;
  logic [ModeW-1:0]  mode_code_q, mode_code_d;

  logic out_free, fire, in_take;
  logic seen_m, seen_l, seen_r, grip;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      middle_thr_q   <= RstMiddleThreshold;
      side_thr_q     <= RstSideThreshold;
      grip_thr_q     <= RstGripThreshold;
      rotate_tout_q  <= RstRotateTimeout;
      miss_limit_q   <= RstMissLimit;
      cruise_speed_q <= RstCruiseSpeed;
      turn_speed_q   <= RstTurnSpeed;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMiddleThreshold: middle_thr_q   <= cfg_data_i[DistW-1:0];
        CfgSideThreshold:   side_thr_q     <= cfg_data_i[DistW-1:0];
        CfgGripThreshold:   grip_thr_q     <= cfg_data_i[DistW-1:0];
        CfgRotateTimeout:   rotate_tout_q  <= cfg_data_i[ToutW-1:0];
        CfgMissLimit:       miss_limit_q   <= cfg_data_i[MissW-1:0];
        CfgCruiseSpeed:     cruise_speed_q <= cfg_data_i[SpeedW-1:0];
        CfgTurnSpeed:       turn_speed_q   <= cfg_data_i[SpeedW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dl_q  <= dist_left_i;
      dm_q  <= dist_middle_i;
      dr_q  <= dist_right_i;
      now_q <= now_ms_i;
    end
  end

  assign seen_m   = dm_q < middle_thr_q;
  assign seen_l   = dl_q < side_thr_q;
  assign seen_r   = dr_q < side_thr_q;
  assign grip     = dm_q < grip_thr_q;
  assign miss_inc = miss_q + 1'b1;

  always_comb begin
    mode_d      = mode_q;
    turn_dir_d  = turn_dir_q;
    deadline_d  = deadline_q;
    miss_d      = miss_q;
    cmd_d       = CmdNone;
    spd_w_d     = 1'b0;
    spd_d       = '0;
    ready_d     = 1'b0;
    extra_d     = 1'b0;
    unique case (mode_q)
      ModeApproach: begin
        if (grip) begin
          miss_d  = '0;
          cmd_d   = CmdStop;
          ready_d = 1'b1;
          mode_d  = ModeSearch;
        end else if (seen_l != seen_r) begin
          miss_d     = '0;
          spd_w_d    = 1'b1;
          spd_d      = turn_speed_q;
          turn_dir_d = seen_r;
          cmd_d      = seen_r ? CmdCw : CmdCcw;
          mode_d     = ModeRotating;
          deadline_d = now_q + {{(TimeW-ToutW){1'b0}}, rotate_tout_q};
        end else if (seen_m || (seen_l && seen_r)) begin
          miss_d  = '0;
          spd_w_d = 1'b1;
          spd_d   = cruise_speed_q;
          cmd_d   = CmdForward;
        end else if (miss_inc >= miss_limit_q) begin
          mode_d = ModeSearch;
          miss_d = '0;
        end else begin
          miss_d = miss_inc;
        end
      end
      ModeRotating: begin
        miss_d = '0;
        cmd_d  = turn_dir_q ? CmdCw : CmdCcw;
        if (seen_m || (now_q >= deadline_q)) begin
          extra_d = 1'b1;
          mode_d  = ModeApproach;
          spd_w_d = 1'b1;
          spd_d   = cruise_speed_q;
          cmd_d   = seen_m ? CmdForward : CmdStop;
        end
      end
      default: begin
        if (seen_l || seen_m || seen_r) begin
          mode_d = ModeApproach;
        end else begin
          mode_d = ModeSearch;
          cmd_d  = CmdForward;
        end
      end
    endcase
    unique case (mode_d)
      ModeApproach: mode_code_d = ModeCodeApproach;
      ModeRotating: mode_code_d = ModeCodeRotating;
      default:      mode_code_d = ModeCodeSearch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeSearch;
      turn_dir_q  <= 1'b0;
      deadline_q  <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
      if (fire) begin
        mode_q     <= mode_d;
        turn_dir_q <= turn_dir_d;
        deadline_q <= deadline_d;
        miss_q     <= miss_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q       <= cmd_d;
      spd_w_q     <= spd_w_d;
      spd_q       <= spd_d;
      ready_q     <= ready_d;
      extra_q     <= extra_d;
      mode_code_q <= mode_code_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_cmd_o   = cmd_q;
  assign speed_write_o = spd_w_q;
  assign speed_value_o = spd_q;
  assign grip_ready_o  = ready_q;
  assign extra_turn_o  = extra_q;
  assign mode_now_o    = mode_code_q;

`ifndef SYNTHESIS
  // A grip ends the approach with a stop and a return to search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ready_q) |-> (cmd_q == CmdStop && mode_code_q == ModeCodeSearch))
    else $error("grip_ready without stop and search");

  // The end of a rotation always applies the cruise speed and goes to approach.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && extra_q) |-> (spd_w_q && spd_q == $past(cruise_speed_q)
                                  && mode_code_q == ModeCodeApproach))
    else $error("extra_turn without cruise speed write");

  // A speed value is only reported together with a speed write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !spd_w_q) |-> (spd_q == '0))
    else $error("speed_value set without speed_write");

  // The miss counter wraps back before reaching its top code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q != {MissW{1'b1}})
    else $error("miss counter reached its top code");

  // A word held in the input register leaves only when the output side frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && out_valid_q))
    else $error("pending word lost during output stall");
`endif

endmodule

/* tb/seek_pass_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target seek pass checker
// Watches the configuration port and both word channels of the three-sonar
// target seek controller, predicts the result word of every accepted pass
// from its own copy of the mode, turn direction, deadline and miss count,
// and compares each accepted result word field by field in order.
// ----------------------------------------------------------------------------
module seek_pass_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsts_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [tsts_pkg::DistW-1:0]    dist_left_i,
  input  logic [tsts_pkg::DistW-1:0]    dist_middle_i,
  input  logic [tsts_pkg::DistW-1:0]    dist_right_i,
  input  logic [tsts_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [tsts_pkg::CmdW-1:0]     motor_cmd_i,
  input  logic                          speed_write_i,
  input  logic [tsts_pkg::SpeedW-1:0]   speed_value_i,
  input  logic                          grip_ready_i,
  input  logic                          extra_turn_i,
  input  logic [tsts_pkg::ModeW-1:0]    mode_now_i,
  output int unsigned                   mismatch_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   grip_cnt_o,
  output int unsigned                   rot_end_cnt_o
);
  import tsts_pkg::*;

  typedef struct packed {
    motor_cmd_e        cmd;
    logic              spd_w;
    logic [SpeedW-1:0] spd;
    logic              ready;
    logic              extra;
    logic [ModeW-1:0]  mode;
  } seek_word_t;

  logic [DistW-1:0]  mid_thr;
  logic [DistW-1:0]  side_thr;
  logic [DistW-1:0]  grip_thr;
  logic [ToutW-1:0]  rot_tout;
  logic [MissW-1:0]  miss_lim;
  logic [SpeedW-1:0] cruise_spd;
  logic [SpeedW-1:0] turn_spd;

  logic [ModeW-1:0]  mode_q;
  logic              cw_q;
  logic [TimeW-1:0]  deadline_q;
  logic [MissW-1:0]  misses_q;

  seek_word_t  expected_words[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned grips;
  int unsigned rot_ends;

  function automatic string show_word(seek_word_t w);
    return $sformatf("cmd=%0d spd_w=%0b spd=%0d grip=%0b extra=%0b mode=%0d",
                     w.cmd, w.spd_w, w.spd, w.ready, w.extra, w.mode);
  endfunction

  // One control pass: updates the predicted state and returns the result word.
  function automatic seek_word_t seek_pass(input logic [DistW-1:0] dl,
                                           input logic [DistW-1:0] dm,
                                           input logic [DistW-1:0] dr,
                                           input logic [TimeW-1:0] now);
    seek_word_t r;
    logic       seen_m;
    logic       seen_l;
    logic       seen_r;
    logic       grip;
    seen_m = dm < mid_thr;
    seen_l = dl < side_thr;
    seen_r = dr < side_thr;
    grip   = dm < grip_thr;
    r      = '0;
    r.cmd  = CmdNone;
    case (mode_q)
      ModeCodeApproach: begin
        if (grip) begin
          misses_q = '0;
          r.cmd    = CmdStop;
          r.ready  = 1'b1;
          mode_q   = ModeCodeSearch;
        end else if (seen_l != seen_r) begin
          misses_q   = '0;
          r.spd_w    = 1'b1;
          r.spd      = turn_spd;
          cw_q       = seen_r;
          r.cmd      = seen_r ? CmdCw : CmdCcw;
          mode_q     = ModeCodeRotating;
          deadline_q = now + TimeW'(rot_tout);
        end else if (seen_m || (seen_l && seen_r)) begin
          misses_q = '0;
          r.spd_w  = 1'b1;
          r.spd    = cruise_spd;
          r.cmd    = CmdForward;
        end else begin
          misses_q = misses_q + 1'b1;
          if (misses_q >= miss_lim) begin
            mode_q   = ModeCodeSearch;
            misses_q = '0;
          end
        end
      end
      ModeCodeRotating: begin
        misses_q = '0;
        r.cmd    = cw_q ? CmdCw : CmdCcw;
        if (seen_m || now >= deadline_q) begin
          r.extra = 1'b1;
          mode_q  = ModeCodeApproach;
          r.spd_w = 1'b1;
          r.spd   = cruise_spd;
          r.cmd   = seen_m ? CmdForward : CmdStop;
        end
      end
      default: begin
        mode_q = ModeCodeSearch;
        if (seen_l || seen_m || seen_r) begin
          mode_q = ModeCodeApproach;
        end else begin
          r.cmd = CmdForward;
        end
      end
    endcase
    r.mode = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    seek_word_t exp_w;
    seek_word_t got_w;
    logic       bad;
    if (!rst_ni) begin
      mid_thr    = RstMiddleThreshold;
      side_thr   = RstSideThreshold;
      grip_thr   = RstGripThreshold;
      rot_tout   = RstRotateTimeout;
      miss_lim   = RstMissLimit;
      cruise_spd = RstCruiseSpeed;
      turn_spd   = RstTurnSpeed;
      mode_q     = ModeCodeSearch;
      cw_q       = 1'b0;
      deadline_q = '0;
      misses_q   = '0;
      expected_words.delete();
      mismatches = 0;
      checked    = 0;
      grips      = 0;
      rot_ends   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMiddleThreshold: mid_thr    = cfg_data_i[DistW-1:0];
          CfgSideThreshold:   side_thr   = cfg_data_i[DistW-1:0];
          CfgGripThreshold:   grip_thr   = cfg_data_i[DistW-1:0];
          CfgRotateTimeout:   rot_tout   = cfg_data_i[ToutW-1:0];
          CfgMissLimit:       miss_lim   = cfg_data_i[MissW-1:0];
          CfgCruiseSpeed:     cruise_spd = cfg_data_i[SpeedW-1:0];
          CfgTurnSpeed:       turn_spd   = cfg_data_i[SpeedW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_w.cmd   = motor_cmd_e'(motor_cmd_i);
        got_w.spd_w = speed_write_i;
        got_w.spd   = speed_value_i;
        got_w.ready = grip_ready_i;
        got_w.extra = extra_turn_i;
        got_w.mode  = mode_now_i;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] Result word with no pass pending: %s", $realtime,
                     show_word(got_w));
          end
        end else begin
          exp_w = expected_words.pop_front();
          checked++;
          if (exp_w.ready) grips++;
          if (exp_w.extra) rot_ends++;
          bad = (got_w.cmd !== exp_w.cmd) || (got_w.spd_w !== exp_w.spd_w) ||
                (got_w.spd !== exp_w.spd) || (got_w.ready !== exp_w.ready) ||
                (got_w.extra !== exp_w.extra) || (got_w.mode !== exp_w.mode);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] Result word %0d differs: expected %s, got %s",
                       $realtime, checked, show_word(exp_w), show_word(got_w));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(seek_pass(dist_left_i, dist_middle_i,
                                           dist_right_i, now_ms_i));
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_words.size();
    checked_o      <= checked;
    grip_cnt_o     <= grips;
    rot_end_cnt_o  <= rot_ends;
  end

endmodule

/* tb/three_sonar_target_seek_fsm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-sonar target seek controller testbench
// Drives sonar pass words through a short directed sequence and then through
// random phases under several register settings, with random idle bursts on
// both channels and one long output hold. A separate checker predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module three_sonar_target_seek_fsm_tb;
  import tsts_pkg::*;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned NumPhases  = 9;
  localparam logic [DistW-1:0] FarDist = '1;

  typedef struct {
    logic [DistW-1:0]  mid;
    logic [DistW-1:0]  side;
    logic [DistW-1:0]  grip;
    logic [ToutW-1:0]  tout;
    logic [MissW-1:0]  miss;
    logic [SpeedW-1:0] cruise;
    logic [SpeedW-1:0] turn;
  } seek_cfg_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [DistW-1:0]    dist_left   = '0;
  logic [DistW-1:0]    dist_middle = '0;
  logic [DistW-1:0]    dist_right  = '0;
  logic [TimeW-1:0]    now_ms      = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [CmdW-1:0]     motor_cmd;
  logic                speed_write;
  logic [SpeedW-1:0]   speed_value;
  logic                grip_ready;
  logic                extra_turn;
  logic [ModeW-1:0]    mode_now;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned grips;
  int unsigned rot_ends;

  logic        calm     = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned sent     = 0;
  int unsigned settings = 0;
  seek_cfg_t   cur;

  three_sonar_target_seek_fsm dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .dist_left_i   (dist_left),
    .dist_middle_i (dist_middle),
    .dist_right_i  (dist_right),
    .now_ms_i      (now_ms),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .motor_cmd_o   (motor_cmd),
    .speed_write_o (speed_write),
    .speed_value_o (speed_value),
    .grip_ready_o  (grip_ready),
    .extra_turn_o  (extra_turn),
    .mode_now_o    (mode_now)
  );

  seek_pass_checker pass_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .dist_left_i    (dist_left),
    .dist_middle_i  (dist_middle),
    .dist_right_i   (dist_right),
    .now_ms_i       (now_ms),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .motor_cmd_i    (motor_cmd),
    .speed_write_i  (speed_write),
    .speed_value_i  (speed_value),
    .grip_ready_i   (grip_ready),
    .extra_turn_i   (extra_turn),
    .mode_now_i     (mode_now),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .grip_cnt_o     (grips),
    .rot_end_cnt_o  (rot_ends)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [DistW-1:0] pick_dist(input logic [DistW-1:0] thr);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return FarDist;
      2, 3:    return thr - 1'b1;
      4:       return thr;
      5, 6:    return (thr == 0) ? '0 : DistW'($urandom_range(0, thr - 1));
      default: return DistW'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_pass(input logic [DistW-1:0] l, input logic [DistW-1:0] m,
                           input logic [DistW-1:0] r, input logic [TimeW-1:0] t);
    int unsigned gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    dist_left   <= l;
    dist_middle <= m;
    dist_right  <= r;
    now_ms      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_settings(input seek_cfg_t s);
    write_reg(CfgMiddleThreshold, CfgDataW'(s.mid));
    write_reg(CfgSideThreshold, CfgDataW'(s.side));
    write_reg(CfgGripThreshold, CfgDataW'(s.grip));
    write_reg(CfgRotateTimeout, CfgDataW'(s.tout));
    write_reg(CfgMissLimit, CfgDataW'(s.miss));
    write_reg(CfgCruiseSpeed, CfgDataW'(s.cruise));
    write_reg(CfgTurnSpeed, CfgDataW'(s.turn));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur = s;
    settings++;
  endtask

  initial begin : receiver
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = 150;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 14);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 24);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("Watchdog expired after %0d idle cycles.", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    seek_cfg_t        s;
    int unsigned      n_items;
    int unsigned      quiet;
    logic [TimeW-1:0] clk_ms;
    logic [DistW-1:0] l;
    logic [DistW-1:0] m;
    logic [DistW-1:0] r;
    cur = '{RstMiddleThreshold, RstSideThreshold, RstGripThreshold, RstRotateTimeout,
            RstMissLimit, RstCruiseSpeed, RstTurnSpeed};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every mode transition under the reset settings, including a deadline
    // that wraps past zero and is therefore already met.
    send_pass(FarDist, FarDist, FarDist, 32'd0);
    send_pass(10'd0, FarDist, FarDist, 32'd1);
    send_pass(FarDist, 10'd5, FarDist, 32'd2);
    send_pass(FarDist, 10'd30, FarDist, 32'd3);
    send_pass(FarDist, 10'd30, FarDist, 32'd4);
    send_pass(10'd20, FarDist, 10'd20, 32'd5);
    send_pass(FarDist, FarDist, FarDist, 32'd6);
    send_pass(FarDist, FarDist, FarDist, 32'd7);
    send_pass(FarDist, FarDist, FarDist, 32'd8);
    send_pass(FarDist, FarDist, FarDist, 32'd9);
    send_pass(FarDist, FarDist, 10'd0, 32'd10);
    send_pass(FarDist, FarDist, 10'd0, 32'hFFFF_F000);
    send_pass(FarDist, FarDist, FarDist, 32'hFFFF_FFFF);
    send_pass(10'd0, FarDist, FarDist, 32'd100);
    send_pass(FarDist, FarDist, FarDist, 32'd5099);
    send_pass(FarDist, FarDist, FarDist, 32'd5100);
    send_pass(FarDist, FarDist, 10'd0, 32'd6000);
    send_pass(FarDist, 10'd49, FarDist, 32'd6001);
    send_pass(10'd49, 10'd50, 10'd50, 32'd6002);
    drain_results();

    clk_ms = $urandom;
    quiet  = 0;
    for (int p = 0; p < NumPhases; p++) begin
      s.mid    = DistW'($urandom_range(10, 600));
      s.side   = DistW'($urandom_range(10, 600));
      s.grip   = DistW'($urandom_range(0, s.mid));
      s.tout   = ($urandom_range(0, 3) == 0) ? ToutW'($urandom) :
                 ToutW'($urandom_range(0, 3000));
      s.miss   = MissW'($urandom_range(1, 15));
      s.cruise = SpeedW'($urandom);
      s.turn   = SpeedW'($urandom);
      n_items  = 225;
      case (p)
        0: begin
          s = '{'0, '0, '0, '0, '0, '0, '0};
          n_items = 60;
        end
        1: begin
          s = '{'1, '1, '1, '1, 4'd15, '1, '1};
          n_items = 60;
        end
        2: s.miss = '0;
        3: s.miss = 4'd1;
        4: s.miss = 4'd15;
        default: ;
      endcase
      if (p == NumPhases - 1) calm = 1'b1;
      load_settings(s);
      for (int i = 0; i < n_items; i++) begin
        if (p == 4 && i == 40) hold_req = 1'b1;
        if (quiet > 0) begin
          l = FarDist;
          m = FarDist;
          r = FarDist;
          quiet--;
        end else begin
          if ($urandom_range(0, 9) == 0) quiet = $urandom_range(1, 16);
          l = pick_dist(cur.side);
          m = ($urandom_range(0, 3) == 0) ? pick_dist(cur.grip) : pick_dist(cur.mid);
          r = pick_dist(cur.side);
        end
        case ($urandom_range(0, 19))
          0:       clk_ms = $urandom;
          1:       clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          2:       clk_ms = clk_ms + TimeW'(cur.tout);
          default: clk_ms = clk_ms + $urandom_range(0, cur.tout / 3 + 20);
        endcase
        send_pass(l, m, r, clk_ms);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d sonar passes under %0d register settings; %0d result words checked.",
             sent, settings + 1, checked);
    $display("Grip stops seen: %0d, rotations ended: %0d.", grips, rot_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
